// File: hdl/aho_pkg.sv
// ----------------------------------------------------------------------------
// Additive harmonic oscillator: shared definitions
// Widths, fixed-point constants, register indexes, sequencer states and the
// partial frequency tables used by the oscillator unit.
// ----------------------------------------------------------------------------
package aho_pkg;

  // Structure of the block.
  localparam int unsigned NUM_PARTIALS      = 8;
  localparam int unsigned PART_W            = 3;
  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam int unsigned PHASE_BITS_DEF    = 32;

  // Port widths.
  localparam int unsigned CV_W       = 16;
  localparam int unsigned OUT_W      = 17;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STIME_W    = 31;
  localparam int unsigned SLIDER_W   = 64;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  // Internal datapath widths.
  localparam int unsigned FREQ_W    = 18;  // frequency in units of 0.01 Hz
  localparam int unsigned QUOT_W    = 25;  // sample_time / 100
  localparam int unsigned REM_W     = 7;   // sample_time % 100
  localparam int unsigned TERM_W    = 25;  // frequency times remainder
  localparam int unsigned TDIV_W    = 18;  // that term / 100
  localparam int unsigned FQ_W      = 43;  // frequency times quotient
  localparam int unsigned SUM_W     = 44;  // increment before the phase shift
  localparam int unsigned AMP_W     = 17;  // Q16 amplitude, 65536 is full scale
  localparam int unsigned ROM_W     = 15;  // signed sine sample
  localparam int unsigned ROM_MAG_W = 14;
  localparam int unsigned ACC_W     = 34;  // signed sum of eight products
  localparam int unsigned MAC_W     = 31;  // one amplitude times sine product
  localparam int unsigned MUL_W     = 32;  // shared multiplier operand width
  localparam int unsigned SCALE_W   = 36;  // magnitude times five plus rounding

  // Division by 100 as a reciprocal multiply, exact for operands below 2^31.
  localparam logic [MUL_W-1:0] RECIP_100       = 32'd2748779070;
  localparam int unsigned      RECIP_100_SHIFT = 38;

  // Division by 5 as a reciprocal multiply, exact for operands below 2^19.
  localparam logic [21:0]  RECIP_5       = 22'd3355444;
  localparam int unsigned  RECIP_5_SHIFT = 24;

  // Amplitude and output scaling.
  localparam logic [CV_W-2:0] CV_FULL     = 15'd20480;  // 10 V
  localparam logic [OUT_W-1:0] OUT_LIMIT  = 17'd51200;  // 25 V
  localparam int unsigned     OUT_SHIFT   = 19;
  localparam logic [SCALE_W-1:0] OUT_ROUND = 36'd262144;

  // Sine table generation, Q30 fixed point.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] PEAK_LSB    = 64'd10240;

  // Configuration register reset values.
  localparam logic [STIME_W-1:0] STIME_RESET = 31'd24931783;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 2'd0,
    CFG_SAMPLE_TIME = 2'd1,
    CFG_SLIDERS     = 2'd2
  } cfg_idx_e;

  // Frequency table selection. The last code stops every partial.
  typedef enum logic [MODE_W-1:0] {
    MODE_HARMONIC = 2'd0,
    MODE_LOG      = 2'd1,
    MODE_SQRT     = 2'd2,
    MODE_OFF      = 2'd3
  } mode_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QDIV,
    ST_QGET,
    ST_TERM,
    ST_TDIV,
    ST_FQ,
    ST_INC,
    ST_UPD,
    ST_IDX,
    ST_ROM,
    ST_MAC,
    ST_ACC,
    ST_OUT
  } aho_state_e;

  // Partial frequency in units of 0.01 Hz.
  function automatic logic [FREQ_W-1:0] freq_centi_hz(input mode_e mode,
                                                      input logic [PART_W-1:0] k);
    logic [FREQ_W-1:0] f;
    f = '0;
    unique case (mode)
      MODE_HARMONIC: begin
        unique case (k)
          3'd0: f = 18'd26163;
          3'd1: f = 18'd52328;
          3'd2: f = 18'd78489;
          3'd3: f = 18'd104673;
          3'd4: f = 18'd130815;
          3'd5: f = 18'd156978;
          3'd6: f = 18'd183141;
          3'd7: f = 18'd209304;
        endcase
      end
      MODE_LOG: begin
        unique case (k)
          3'd0: f = 18'd26163;
          3'd1: f = 18'd52328;
          3'd2: f = 18'd90524;
          3'd3: f = 18'd104673;
          3'd4: f = 18'd146938;
          3'd5: f = 18'd181050;
          3'd6: f = 18'd199392;
          3'd7: f = 18'd209488;
        endcase
      end
      MODE_SQRT: begin
        unique case (k)
          3'd0: f = 18'd26163;
          3'd1: f = 18'd52328;
          3'd2: f = 18'd86782;
          3'd3: f = 18'd104673;
          3'd4: f = 18'd138474;
          3'd5: f = 18'd173609;
          3'd6: f = 18'd195828;
          3'd7: f = 18'd209488;
        endcase
      end
      MODE_OFF: f = '0;
    endcase
    return f;
  endfunction

endpackage

// File: hdl/additive_harmonic_oscillator_unit.sv
// ----------------------------------------------------------------------------
// Additive harmonic oscillator unit
// Eight-partial sine oscillator: per-partial phase accumulators, a sine ROM,
// amplitude selection from control voltage or slider, and a mixed output.
// ----------------------------------------------------------------------------
// Each input beat is one audio sample tick carrying eight amplitude voltages
// and a mask of which are connected. The unit advances the eight phases,
// looks up the sine of each, weights it by its amplitude and returns one mixed
// sample beat. One 32 x 32 multiplier is shared by the period, increment and
// amplitude products under a small sequencer. From one accepted input beat to
// the next it splits the sample period by 100 (QDIV, QGET), works each of the
// eight partials in TERM, TDIV, FQ, INC, UPD, IDX, ROM, MAC and ACC (four of
// them are multiplier passes, the others form the increment, update the phase,
// form the ROM address, read the ROM and accumulate), scales the sum in OUT and
// returns to IDLE, in which the next beat is taken. The input is not ready while
// a sample is in work. The finished sample sits in an output register, so the
// next input beat can be taken before it is collected; the unit only holds in
// its last step if the previous sample is still waiting.
// Configuration writes are taken at any time and are expected between samples.

module additive_harmonic_oscillator_unit import aho_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned PHASE_BITS    = PHASE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // Input channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [CV_W-1:0]  cv_1_i,
  input  logic signed [CV_W-1:0]  cv_2_i,
  input  logic signed [CV_W-1:0]  cv_3_i,
  input  logic signed [CV_W-1:0]  cv_4_i,
  input  logic signed [CV_W-1:0]  cv_5_i,
  input  logic signed [CV_W-1:0]  cv_6_i,
  input  logic signed [CV_W-1:0]  cv_7_i,
  input  logic signed [CV_W-1:0]  cv_8_i,
  input  logic [NUM_PARTIALS-1:0] connected_mask_i,
  // Output channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] out_sample_o
);

  localparam int unsigned IDX_W       = $clog2(TABLE_ENTRIES);
  localparam int unsigned TE_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IDX_PROD_W  = PHASE_BITS + TE_W;
  localparam int unsigned PHASE_SHIFT = 40 - PHASE_BITS;
  localparam logic [TE_W-1:0] TE_CONST = TE_W'(TABLE_ENTRIES);

  // One sine table entry: quadrant folding and an odd Taylor series to the
  // eleventh power in Q30, then rounded half up in magnitude.
  function automatic logic signed [ROM_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] q4;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] unum;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t3;
    logic [63:0] t5;
    logic [63:0] t7;
    logic [63:0] t9;
    logic [63:0] t11;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] mag;
    q4   = 64'(i) << 2;
    quad = q4 / TABLE_ENTRIES;
    rem  = q4 % TABLE_ENTRIES;
    unum = quad[0] ? (64'(TABLE_ENTRIES) - rem) : rem;
    x    = (HALF_PI_Q30 * unum) / TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    t3   = ((x * x2) >> 30) / 6;
    t5   = ((t3 * x2) >> 30) / 20;
    t7   = ((t5 * x2) >> 30) / 42;
    t9   = ((t7 * x2) >> 30) / 72;
    t11  = ((t9 * x2) >> 30) / 110;
    pos  = x + t5 + t9;
    neg  = t3 + t7 + t11;
    s    = (pos > neg) ? (pos - neg) : 64'd0;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    mag = (s * PEAK_LSB + (ONE_Q30 >> 1)) >> 30;
    return (quad >= 64'd2) ? ROM_W'(64'd0 - mag) : ROM_W'(mag);
  endfunction

  // Sine ROM contents.
  logic signed [ROM_W-1:0] sine_rom [TABLE_ENTRIES];

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_rom
    assign sine_rom[gi] = sine_entry(gi);
  end

  // Control and configuration state.
  aho_state_e               state_q, state_d;
  logic [PART_W-1:0]        part_q;
  mode_e                    mode_q;
  logic [STIME_W-1:0]       stime_q;
  logic [SLIDER_W-1:0]      slider_q;
  logic [PHASE_BITS-1:0]    phase_q [NUM_PARTIALS];
  logic                     out_valid_q;

  // Datapath registers.
  logic signed [CV_W-1:0]   cv_q [NUM_PARTIALS];
  logic [NUM_PARTIALS-1:0]  mask_q;
  logic [2*MUL_W-1:0]       prod_q;
  logic [QUOT_W-1:0]        quot_q;
  logic [REM_W-1:0]         rem_q;
  logic [TDIV_W-1:0]        tdiv_q;
  logic [PHASE_BITS-1:0]    inc_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [ROM_W-1:0]  rom_q;
  logic [AMP_W-1:0]         amp_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [OUT_W-1:0]  out_q;

  // Sequencer outputs.
  logic                     accept;
  logic                     out_load;
  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;

  // Combinational datapath signals.
  logic [FREQ_W-1:0]        freq;
  logic [QUOT_W-1:0]        quot_d;
  logic [STIME_W-1:0]       quot_x100;
  logic signed [CV_W-1:0]   cv_sel;
  logic [CV_W-2:0]          cv_clamp;
  logic [40:0]              cv_scaled;
  logic [7:0]               slider_byte;
  logic [AMP_W-1:0]         amp_d;
  logic [SUM_W-1:0]         inc_sum;
  logic [SUM_W-1:0]         inc_shift;
  logic [IDX_PROD_W-1:0]    idx_prod;
  logic [ROM_W-1:0]         rom_abs;
  logic signed [ACC_W-1:0]  mac_term;
  logic [ACC_W-1:0]         acc_abs;
  logic [SCALE_W-1:0]       scaled;
  logic [OUT_W-1:0]         rounded;
  logic [OUT_W-1:0]         clamped;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_QDIV;
      ST_QDIV: state_d = ST_QGET;
      ST_QGET: state_d = ST_TERM;
      ST_TERM: state_d = ST_TDIV;
      ST_TDIV: state_d = ST_FQ;
      ST_FQ:   state_d = ST_INC;
      ST_INC:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_IDX;
      ST_IDX:  state_d = ST_ROM;
      ST_ROM:  state_d = ST_MAC;
      ST_MAC:  state_d = ST_ACC;
      ST_ACC: begin
        if (part_q == PART_W'(NUM_PARTIALS - 1)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_TERM;
        end
      end
      ST_OUT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and operand selection for the multiplier.
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_QDIV: begin
        mul_a = MUL_W'(stime_q);
        mul_b = RECIP_100;
      end
      ST_TERM: begin
        mul_a = MUL_W'(freq);
        mul_b = MUL_W'(rem_q);
      end
      ST_TDIV: begin
        mul_a = MUL_W'(prod_q[TERM_W-1:0]);
        mul_b = RECIP_100;
      end
      ST_FQ: begin
        mul_a = MUL_W'(freq);
        mul_b = MUL_W'(quot_q);
      end
      ST_MAC: begin
        mul_a = MUL_W'(amp_q);
        mul_b = MUL_W'(rom_abs[ROM_MAG_W-1:0]);
      end
      ST_OUT:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // Frequency of the partial in work.
  assign freq = freq_centi_hz(mode_q, part_q);

  // Sample period split into quotient and remainder by 100.
  assign quot_d    = prod_q[RECIP_100_SHIFT +: QUOT_W];
  assign quot_x100 = STIME_W'(quot_d) * STIME_W'(100);

  // Amplitude: clamped voltage times 16/5, or slider byte times 65536/255.
  assign cv_sel      = cv_q[part_q];
  assign cv_clamp    = cv_sel[CV_W-1] ? '0 :
                       ((cv_sel[CV_W-2:0] > CV_FULL) ? CV_FULL : cv_sel[CV_W-2:0]);
  assign cv_scaled   = 41'({cv_clamp, 4'b0000}) * 41'(RECIP_5);
  assign slider_byte = slider_q[{part_q, 3'b000} +: 8];
  assign amp_d       = mask_q[part_q] ? cv_scaled[RECIP_5_SHIFT +: AMP_W] :
                       (AMP_W'({slider_byte, slider_byte}) + AMP_W'(slider_byte[7]));

  // Phase increment: frequency times period, in phase units.
  assign inc_sum   = SUM_W'(prod_q[FQ_W-1:0]) + SUM_W'(tdiv_q);
  assign inc_shift = inc_sum >> PHASE_SHIFT;

  // ROM address from the new phase.
  assign idx_prod = IDX_PROD_W'(phase_q[part_q]) * IDX_PROD_W'(TE_CONST);

  // Product of amplitude and sine magnitude, signed by the sine.
  assign rom_abs  = rom_q[ROM_W-1] ? ROM_W'(-rom_q) : ROM_W'(rom_q);
  assign mac_term = $signed(ACC_W'(prod_q[MAC_W-1:0]));

  // Output scaling by 5/2^19, rounded half away from zero and clamped.
  assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign scaled  = SCALE_W'(acc_abs) * SCALE_W'(5) + OUT_ROUND;
  assign rounded = scaled[OUT_SHIFT +: OUT_W];
  assign clamped = (rounded > OUT_LIMIT) ? OUT_LIMIT : rounded;

  // Sequencer state and partial counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      part_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        part_q <= '0;
      end else if (state_q == ST_ACC) begin
        part_q <= part_q + PART_W'(1);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_HARMONIC;
      stime_q  <= STIME_RESET;
      slider_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:        mode_q   <= mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_SAMPLE_TIME: stime_q  <= cfg_data_i[STIME_W-1:0];
        CFG_SLIDERS:     slider_q <= cfg_data_i[SLIDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase accumulators, one per partial, updated in turn.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_PARTIALS; k++) begin
        phase_q[k] <= '0;
      end
    end else if (state_q == ST_UPD) begin
      phase_q[part_q] <= phase_q[part_q] + inc_q;
    end
  end

  // Output beat register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Shared multiplier, result registered every cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Datapath registers loaded by the sequencer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cv_q[0] <= cv_1_i;
      cv_q[1] <= cv_2_i;
      cv_q[2] <= cv_3_i;
      cv_q[3] <= cv_4_i;
      cv_q[4] <= cv_5_i;
      cv_q[5] <= cv_6_i;
      cv_q[6] <= cv_7_i;
      cv_q[7] <= cv_8_i;
      mask_q  <= connected_mask_i;
      acc_q   <= '0;
    end
    if (state_q == ST_QGET) begin
      quot_q <= quot_d;
      rem_q  <= REM_W'(stime_q - quot_x100);
    end
    if (state_q == ST_TERM) begin
      amp_q <= amp_d;
    end
    if (state_q == ST_FQ) begin
      tdiv_q <= prod_q[RECIP_100_SHIFT +: TDIV_W];
    end
    if (state_q == ST_INC) begin
      inc_q <= inc_shift[PHASE_BITS-1:0];
    end
    if (state_q == ST_IDX) begin
      idx_q <= idx_prod[PHASE_BITS +: IDX_W];
    end
    if (state_q == ST_ACC) begin
      acc_q <= rom_q[ROM_W-1] ? (acc_q - mac_term) : (acc_q + mac_term);
    end
    if (out_load) begin
      out_q <= acc_q[ACC_W-1] ? $signed(OUT_W'(17'd0 - clamped)) : $signed(clamped);
    end
  end

  // Sine ROM read, data registered.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROM) begin
      rom_q <= sine_rom[idx_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  // An accepted beat always starts the period split.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_QDIV))
    else $error("accepted input beat did not start the sequence");

  // The reciprocal division must leave a remainder below 100.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TERM) |-> (rem_q < REM_W'(100)))
    else $error("sample period remainder out of range");

  // A new output beat only appears from the final step.
  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_OUT))
    else $error("output beat raised outside the final step");

  // A presented sample is always within the output limit.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_sample_o <= 17'sd51200) && (out_sample_o >= -17'sd51200)))
    else $error("output sample beyond limit");

  // The partial counter holds in the final step and while the quotient is taken.
  a_part_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_OUT) || (state_q == ST_QGET)) |=> $stable(part_q))
    else $error("partial counter moved outside the partial loop");

endmodule
